// ===== src/rfcl_pkg.sv =====
// Shared widths, codes and payload types for the remote-code learner.
package rfcl_pkg;

  localparam int CODE_BITS = 32;
  localparam int NUM_SLOTS = 4;

  localparam int REQ_W      = 2;
  localparam int CODE_IN_W  = 32;
  localparam int SLOT_W     = 2;
  localparam int WINDOW_W   = 20;
  localparam int HOLDOFF_W  = 16;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // bits of the incoming code that a slot keeps
  localparam int CODE_KEEP = (CODE_BITS < CODE_IN_W) ? CODE_BITS : CODE_IN_W;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CODE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LEARN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF      = 1'd1;

  localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 20'd10000;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd500;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [CODE_IN_W-1:0] code_value;
    logic [SLOT_W-1:0]    learn_slot;
  } item_t;

  typedef struct packed {
    logic              action_fired;
    logic [SLOT_W-1:0] action;
    logic              code_learned;
    logic [SLOT_W-1:0] learned_slot;
    logic              learn_expired;
    logic              learning_now;
  } result_t;

  typedef struct packed {
    logic [WINDOW_W-1:0]  learn_window_ticks;
    logic [HOLDOFF_W-1:0] holdoff_ticks;
  } cfg_t;

endpackage

// ===== src/rfcl_if.sv =====
// Request and result channel interfaces.
interface rfcl_req_if
  import rfcl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [CODE_IN_W-1:0] code_value;
  logic [SLOT_W-1:0]    learn_slot;

  modport source (output valid, output req_type, output code_value, output learn_slot,
                  input ready);
  modport sink   (input valid, input req_type, input code_value, input learn_slot,
                  output ready);
endinterface

interface rfcl_res_if
  import rfcl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action_fired;
  logic [SLOT_W-1:0] action;
  logic              code_learned;
  logic [SLOT_W-1:0] learned_slot;
  logic              learn_expired;
  logic              learning_now;

  modport source (output valid, output action_fired, output action, output code_learned,
                  output learned_slot, output learn_expired, output learning_now,
                  input ready);
  modport sink   (input valid, input action_fired, input action, input code_learned,
                  input learned_slot, input learn_expired, input learning_now,
                  output ready);
endinterface

// ===== src/rfcl_cfg_regs.sv =====
// Configuration registers: learning window and fire holdoff.
module rfcl_cfg_regs
  import rfcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_window_ticks <= WINDOW_RESET;
      cfg.holdoff_ticks      <= HOLDOFF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEARN_WINDOW: cfg.learn_window_ticks <= cfg_data[WINDOW_W-1:0];
        CFG_HOLDOFF:      cfg.holdoff_ticks      <= cfg_data[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/rfcl_engine.sv =====
// Slot store, learning session, tick counter and match/holdoff logic.
module rfcl_engine
  import rfcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [CODE_BITS-1:0] code_slots      [NUM_SLOTS];
  logic [CODE_BITS-1:0] code_slots_next [NUM_SLOTS];
  logic                 learn_armed, learn_armed_next;
  logic [SLOT_W-1:0]    armed_slot, armed_slot_next;
  logic [WINDOW_W-1:0]  learn_elapsed, learn_elapsed_next;
  logic [TICK_W-1:0]    tick_now, tick_now_next;
  logic [TICK_W-1:0]    last_fire_time, last_fire_time_next;

  logic [CODE_BITS-1:0] code_kept;
  logic                 hit_found;
  logic [SLOT_W-1:0]    hit_idx;
  logic [TICK_W-1:0]    since_fire;
  logic [WINDOW_W-1:0]  elapsed_inc;

  assign code_kept  = CODE_BITS'(item.code_value[CODE_KEEP-1:0]);
  assign since_fire = tick_now - last_fire_time;
  assign elapsed_inc = (learn_elapsed == {WINDOW_W{1'b1}}) ? learn_elapsed
                                                           : learn_elapsed + 1'b1;

  // lowest-numbered nonzero equal slot wins
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (code_slots[i] != '0 && code_slots[i] == code_kept) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    logic armed_after_check;
    code_slots_next     = code_slots;
    learn_armed_next    = learn_armed;
    armed_slot_next     = armed_slot;
    learn_elapsed_next  = learn_elapsed;
    tick_now_next       = tick_now;
    last_fire_time_next = last_fire_time;
    result              = '0;

    // expiry test ahead of the request
    armed_after_check = learn_armed;
    if (learn_armed && learn_elapsed > cfg.learn_window_ticks) begin
      armed_after_check    = 1'b0;
      result.learn_expired = 1'b1;
    end
    learn_armed_next = armed_after_check;

    case (item.req_type)
      REQ_TICK: begin
        tick_now_next = tick_now + 1'b1;
        if (armed_after_check) begin
          learn_elapsed_next = elapsed_inc;
          if (elapsed_inc > cfg.learn_window_ticks) begin
            learn_armed_next     = 1'b0;
            result.learn_expired = 1'b1;
          end
        end
      end
      REQ_CODE: begin
        if (armed_after_check) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (int'(armed_slot) == i) code_slots_next[i] = code_kept;
          end
          result.code_learned = 1'b1;
          result.learned_slot = armed_slot;
          learn_armed_next    = 1'b0;
        end else if (hit_found && since_fire > TICK_W'(cfg.holdoff_ticks)) begin
          result.action_fired = 1'b1;
          result.action       = hit_idx;
          last_fire_time_next = tick_now;
        end
      end
      REQ_LEARN: begin
        // ignore a slot beyond the store
        if (int'(item.learn_slot) < NUM_SLOTS) begin
          learn_armed_next   = 1'b1;
          armed_slot_next    = item.learn_slot;
          learn_elapsed_next = '0;
        end
      end
      default: ;
    endcase

    result.learning_now = learn_armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) code_slots[i] <= '0;
      learn_armed    <= 1'b0;
      armed_slot     <= '0;
      learn_elapsed  <= '0;
      tick_now       <= '0;
      last_fire_time <= '0;
    end else if (step) begin
      code_slots     <= code_slots_next;
      learn_armed    <= learn_armed_next;
      armed_slot     <= armed_slot_next;
      learn_elapsed  <= learn_elapsed_next;
      tick_now       <= tick_now_next;
      last_fire_time <= last_fire_time_next;
    end
  end

endmodule

// ===== src/rf_code_learn_and_match.sv =====
// Top level: input register, engine, result register and configuration port.
// Every request beat (tick, received code or start-learning) yields exactly one
// result beat. A beat accepted on req is held in the input register, processed
// there by the slot comparators and session counters, and is then captured in
// the result register that drives res; a new beat can be taken in every cycle
// while res is being drained, so throughput is one beat per cycle, set by the
// combinational compare and counter update in the engine.
// Configuration writes take effect on the next beat and should be made with the
// block idle. There is no clearing pass: the four code slots reset to empty.
module rf_code_learn_and_match
  import rfcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rfcl_req_if.sink              req,
  rfcl_res_if.source            res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    stage_valid;
  item_t   stage_item;
  logic    res_valid;
  result_t res_data;
  result_t engine_result;
  logic    advance;

  // stage moves on when the result register is empty or being drained
  assign advance   = !res_valid || res.ready;
  assign req.ready = !stage_valid || advance;

  rfcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfcl_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (stage_valid && advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (engine_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage_item.req_type   <= req.req_type;
      stage_item.code_value <= req.code_value;
      stage_item.learn_slot <= req.learn_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res_data <= engine_result;
    end
  end

  assign res.valid         = res_valid;
  assign res.action_fired  = res_data.action_fired;
  assign res.action        = res_data.action;
  assign res.code_learned  = res_data.code_learned;
  assign res.learned_slot  = res_data.learned_slot;
  assign res.learn_expired = res_data.learn_expired;
  assign res.learning_now  = res_data.learning_now;

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || res.ready) |-> req.ready)
    else $error("request side stalled with a free result register");

  a_stage_to_result: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> res_valid)
    else $error("processed beat did not reach the result register");

  a_session_closed: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.action_fired || res_data.code_learned)) |-> !res_data.learning_now)
    else $error("session still armed after a fire or a learned code");

  a_fire_or_learn: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.action_fired && res_data.code_learned))
    else $error("one beat both fired and learned");

endmodule
